// ----- design/heapsort_engine_assert.svh -----
// ----------------------------------------------------------------------------
// heapsort_engine_assert.svh
// Assertion macros used by the heapsort engine core. Each expects clk
// and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef HEAPSORT_ENGINE_ASSERT_SVH
`define HEAPSORT_ENGINE_ASSERT_SVH

// same-cycle implication
`define HSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/hse_pkg.sv -----
// ----------------------------------------------------------------------------
// hse_pkg
// Word types and command codes of the heapsort engine.
// ----------------------------------------------------------------------------
package hse_pkg;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam int VALUE_W = 32;
    localparam int CALLS_W = 16;

    typedef struct packed {
        logic                      func;
        logic signed [VALUE_W-1:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic [CALLS_W-1:0]        sift_calls;
        logic                      last;
    } res_word_t;

endpackage

// ----- design/hse_ram.sv -----
// ----------------------------------------------------------------------------
// hse_ram
// Heap store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module hse_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata0,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data while no read is issued
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

// ----- design/hse_core.sv -----
// ----------------------------------------------------------------------------
// hse_core
// Load/sort/read sequencer. Sorts in place with hole-style sift-down: the
// sifted key stays in a register while larger children move up.
// ----------------------------------------------------------------------------
`include "heapsort_engine_assert.svh"

module hse_core #(
    parameter int MAX_ITEMS = 1024,
    parameter int KW        = 32,
    parameter int IW        = 11,
    parameter int AW        = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  hse_pkg::cmd_word_t cmd,
    output logic               rsp_valid,
    input  logic               rsp_free,
    output hse_pkg::res_word_t rsp,
    output logic               we,
    output logic [AW-1:0]      waddr,
    output logic [KW-1:0]      wdata,
    output logic               re,
    output logic [AW-1:0]      ra0,
    output logic [AW-1:0]      ra1,
    input  logic [KW-1:0]      rd0,
    input  logic [KW-1:0]      rd1
);

    localparam logic [KW-1:0] KEY_SIGN = ~({KW{1'b1}} >> 1);
    localparam logic [IW-1:0] MAX_CNT  = IW'(MAX_ITEMS);
    localparam logic [IW-1:0] ONE_IDX  = IW'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BUILD_RD,
        ST_BUILD_LD,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_EXT_RD,
        ST_EXT_SW,
        ST_OUT_RD,
        ST_OUT_WAIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [IW-1:0]               count_reg, count_next;
    logic [IW-1:0]               size_reg, size_next;
    logic [IW-1:0]               rp_reg, rp_next;
    logic                        sorted_reg, sorted_next;
    logic [hse_pkg::CALLS_W-1:0] sift_reg, sift_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic [IW-1:0]               build_reg, build_next;
    logic [KW-1:0]               v_reg, v_next;

    logic [IW:0]                 l_idx, r_idx, size_x;
    logic                        l_ok, r_ok;
    logic                        take_l, take_r;
    logic [KW-1:0]               best;
    logic                        sift_done;
    logic                        accept;
    logic signed [KW-1:0]        out_val;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;

    assign l_idx  = {idx_reg, 1'b0};
    assign r_idx  = l_idx + (IW+1)'(1);
    assign size_x = {1'b0, size_reg};
    assign l_ok   = (l_idx <= size_x);
    assign r_ok   = (r_idx <= size_x);
    assign take_l = (v_reg < rd0);
    assign best   = take_l ? rd0 : v_reg;
    assign take_r = r_ok && (best < rd1);

    assign out_val          = rd0 ^ KEY_SIGN;
    assign rsp.sorted_value = hse_pkg::VALUE_W'(out_val);
    assign rsp.sift_calls   = sift_reg;
    assign rsp.last         = (IW'(rp_reg + ONE_IDX) == count_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        size_next   = size_reg;
        rp_next     = rp_reg;
        sorted_next = sorted_reg;
        sift_next   = sift_reg;
        idx_next    = idx_reg;
        build_next  = build_reg;
        v_next      = v_reg;
        we          = 1'b0;
        waddr       = '0;
        wdata       = v_reg;
        re          = 1'b0;
        ra0         = '0;
        ra1         = '0;
        rsp_valid   = 1'b0;
        sift_done   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.func == hse_pkg::FUNC_LOAD)
                begin
                    wdata = cmd.value[KW-1:0] ^ KEY_SIGN;
                    if (sorted_reg)
                    begin
                        // drop the old set, start a new one with this word
                        we          = 1'b1;
                        waddr       = '0;
                        count_next  = ONE_IDX;
                        size_next   = '0;
                        rp_next     = '0;
                        sorted_next = 1'b0;
                        sift_next   = '0;
                    end
                    else if (count_reg < MAX_CNT)
                    begin
                        we         = 1'b1;
                        waddr      = AW'(count_reg);
                        count_next = count_reg + ONE_IDX;
                    end
                end
                else if (accept && count_reg != '0)
                begin
                    if (!sorted_reg)
                    begin
                        sift_next  = '0;
                        size_next  = count_reg;
                        build_next = count_reg >> 1;
                        state_next = ((count_reg >> 1) == '0) ? ST_EXT_RD : ST_BUILD_RD;
                    end
                    else if (rp_reg < count_reg)
                    begin
                        state_next = ST_OUT_RD;
                    end
                end
            end

            ST_BUILD_RD:
            begin
                re         = 1'b1;
                ra0        = AW'(build_reg - ONE_IDX);
                state_next = ST_BUILD_LD;
            end

            ST_BUILD_LD:
            begin
                v_next     = rd0;
                idx_next   = build_reg;
                state_next = ST_SIFT_RD;
            end

            ST_SIFT_RD:
            begin
                if (sift_reg != '1)
                begin
                    sift_next = sift_reg + 1'b1;
                end
                if (!l_ok)
                begin
                    we        = 1'b1;
                    waddr     = AW'(idx_reg - ONE_IDX);
                    sift_done = 1'b1;
                end
                else
                begin
                    re         = 1'b1;
                    ra0        = AW'(l_idx - (IW+1)'(1));
                    ra1        = AW'(r_idx - (IW+1)'(1));
                    state_next = ST_SIFT_CMP;
                end
            end

            ST_SIFT_CMP:
            begin
                we    = 1'b1;
                waddr = AW'(idx_reg - ONE_IDX);
                if (take_r)
                begin
                    wdata      = rd1;
                    idx_next   = IW'(r_idx);
                    state_next = ST_SIFT_RD;
                end
                else if (take_l)
                begin
                    wdata      = rd0;
                    idx_next   = IW'(l_idx);
                    state_next = ST_SIFT_RD;
                end
                else
                begin
                    sift_done = 1'b1;
                end
            end

            ST_EXT_RD:
            begin
                if (size_reg == '0)
                begin
                    sorted_next = 1'b1;
                    rp_next     = '0;
                    state_next  = ST_OUT_RD;
                end
                else
                begin
                    re         = 1'b1;
                    ra0        = '0;
                    ra1        = AW'(size_reg - ONE_IDX);
                    state_next = ST_EXT_SW;
                end
            end

            ST_EXT_SW:
            begin
                // old root goes to the tail, tail key sifts down from the root
                we        = 1'b1;
                waddr     = AW'(size_reg - ONE_IDX);
                wdata     = rd0;
                v_next    = rd1;
                size_next = size_reg - ONE_IDX;
                idx_next  = ONE_IDX;
                state_next = (size_reg == ONE_IDX) ? ST_EXT_RD : ST_SIFT_RD;
            end

            ST_OUT_RD:
            begin
                re         = 1'b1;
                ra0        = AW'(rp_reg);
                state_next = ST_OUT_WAIT;
            end

            ST_OUT_WAIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid  = 1'b1;
                    rp_next    = rp_reg + ONE_IDX;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (sift_done)
        begin
            if (build_reg != '0)
            begin
                build_next = build_reg - ONE_IDX;
                state_next = (build_reg == ONE_IDX) ? ST_EXT_RD : ST_BUILD_RD;
            end
            else
            begin
                state_next = ST_EXT_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            size_reg   <= '0;
            rp_reg     <= '0;
            sorted_reg <= 1'b0;
            sift_reg   <= '0;
            idx_reg    <= '0;
            build_reg  <= '0;
            v_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            size_reg   <= size_next;
            rp_reg     <= rp_next;
            sorted_reg <= sorted_next;
            sift_reg   <= sift_next;
            idx_reg    <= idx_next;
            build_reg  <= build_next;
            v_reg      <= v_next;
        end
    end

    `HSE_ASSERT_NOW(a_no_rw_collision, we && re, (waddr != ra0) && (waddr != ra1), "heap store read and write hit one entry")
    `HSE_ASSERT_NOW(a_rp_in_range, 1'b1, rp_reg <= count_reg, "read pointer past element count")
    `HSE_ASSERT_NOW(a_size_in_range, 1'b1, size_reg <= count_reg, "heap size past element count")
    `HSE_ASSERT_NOW(a_rsp_when_sorted, rsp_valid, sorted_reg, "result word before the set is sorted")
    `HSE_ASSERT_NEXT(a_sift_monotonic, state_reg != ST_IDLE, sift_reg >= $past(sift_reg), "sift count went down during a sort")

endmodule

// ----- design/heapsort_engine.sv -----
// ----------------------------------------------------------------------------
// heapsort_engine
// Loads signed words into a heap store, sorts them on the first read and
// returns them one per read in ascending order.
//
//   channel | ports                        | word
//   command | cmd_valid, cmd_stall, cmd    | func, value
//   result  | res_valid, res_stall, res    | sorted_value, sift_calls, last
//
// The first read of a set also sorts it. Each sift step is a store read,
// then a compare and write back; each sift starts with a read of its key.
// Reset clears the control registers; store contents stay undefined.
// A stalled result holds in the output register; loads continue meanwhile.
// ----------------------------------------------------------------------------
module heapsort_engine #(
    parameter int MAX_ITEMS  = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  hse_pkg::cmd_word_t cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output hse_pkg::res_word_t res
);

    localparam int KW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int IW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);

    logic               core_valid;
    logic               core_free;
    hse_pkg::res_word_t core_word;
    logic               we, re;
    logic [AW-1:0]      waddr, ra0, ra1;
    logic [KW-1:0]      wdata, rd0, rd1;

    logic               res_valid_reg;
    hse_pkg::res_word_t res_reg;

    assign core_free = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    hse_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (KW),
        .AW    (AW)
    ) u_ram (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .re     (re),
        .raddr0 (ra0),
        .raddr1 (ra1),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    hse_core #(
        .MAX_ITEMS (MAX_ITEMS),
        .KW        (KW),
        .IW        (IW),
        .AW        (AW)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (core_valid),
        .rsp_free  (core_free),
        .rsp       (core_word),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .re        (re),
        .ra0       (ra0),
        .ra1       (ra1),
        .rd0       (rd0),
        .rd1       (rd1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (core_valid)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // hold the result word until it is taken
    always_ff @(posedge clk)
    begin
        if (core_valid)
        begin
            res_reg <= core_word;
        end
    end

endmodule
